// File: sv/source_text_tokenizer_defines.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/stt_pkg.sv
// Types, constants and lookup functions of the source text tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

  // Position counters cover 0..4096
  localparam int POS_W = 13;
  localparam int NKW   = 18;

  // Input item commands
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_EOL  = 1'b1;

  // Token kinds
  localparam logic [2:0] KIND_KEYWORD    = 3'd0;
  localparam logic [2:0] KIND_LITERAL    = 3'd1;
  localparam logic [2:0] KIND_IDENTIFIER = 3'd2;
  localparam logic [2:0] KIND_OPERATOR   = 3'd3;
  localparam logic [2:0] KIND_OTHER      = 3'd4;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_value;
  } char_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [4:0]  table_code;
    logic [11:0] token_start;
    logic [12:0] token_length;
    logic        clipped;
    logic        last_of_run;
  } token_t;

  // Up to two tokens produced by one item
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } step_out_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] code;
  } code_match_t;

  // Keyword text, right-justified, first character in the highest used byte
  localparam logic [63:0] KW_TEXT [0:NKW-1] = '{
    64'("let"), 64'("fun"), 64'("if"), 64'("else"), 64'("for"), 64'("while"),
    64'("do"), 64'("return"), 64'("delete"), 64'("int"), 64'("char"),
    64'("bool"), 64'("void"), 64'("float"), 64'("true"), 64'("false"),
    64'("break"), 64'("continue")
  };
  localparam logic [3:0] KW_SIZE [0:NKW-1] = '{
    4'd3, 4'd3, 4'd2, 4'd4, 4'd3, 4'd5, 4'd2, 4'd6, 4'd6,
    4'd3, 4'd4, 4'd4, 4'd4, 4'd5, 4'd4, 4'd5, 4'd5, 4'd8
  };

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_ident_start(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  // Single-character operators
  function automatic code_match_t single_code(logic [7:0] c);
    code_match_t m;
    m.hit = 1'b1;
    case (c)
      "+":     m.code = 5'd0;
      "-":     m.code = 5'd1;
      "*":     m.code = 5'd2;
      "/":     m.code = 5'd3;
      "%":     m.code = 5'd4;
      "<":     m.code = 5'd7;
      ">":     m.code = 5'd8;
      "!":     m.code = 5'd13;
      "=":     m.code = 5'd14;
      ",":     m.code = 5'd20;
      "(":     m.code = 5'd21;
      ")":     m.code = 5'd22;
      ".":     m.code = 5'd23;
      "[":     m.code = 5'd24;
      "]":     m.code = 5'd25;
      "{":     m.code = 5'd26;
      "}":     m.code = 5'd27;
      default: begin
        m.hit  = 1'b0;
        m.code = 5'd0;
      end
    endcase
    return m;
  endfunction

  // Two-character operators
  function automatic code_match_t pair_code(logic [7:0] a, logic [7:0] b);
    code_match_t m;
    m.hit = 1'b1;
    case ({a, b})
      "==":    m.code = 5'd5;
      "!=":    m.code = 5'd6;
      "<=":    m.code = 5'd9;
      ">=":    m.code = 5'd10;
      "&&":    m.code = 5'd11;
      "||":    m.code = 5'd12;
      "*=":    m.code = 5'd15;
      "/=":    m.code = 5'd16;
      "%=":    m.code = 5'd17;
      "+=":    m.code = 5'd18;
      "-=":    m.code = 5'd19;
      default: begin
        m.hit  = 1'b0;
        m.code = 5'd0;
      end
    endcase
    return m;
  endfunction

  // Operator characters: the single operators plus lone & and |
  function automatic logic is_op_char(logic [7:0] c);
    code_match_t m;
    m = single_code(c);
    return m.hit || (c == "&") || (c == "|");
  endfunction

  // Keep the keywords whose character at depth cnt equals c
  function automatic logic [NKW-1:0] kw_step(logic [NKW-1:0] mask, logic [3:0] cnt,
                                             logic [7:0] c);
    logic [NKW-1:0] nm;
    int             b;
    nm = '0;
    for (int j = 0; j < NKW; j++) begin
      if (cnt < KW_SIZE[j]) begin
        b     = 8 * (int'(KW_SIZE[j]) - 1 - int'(cnt));
        nm[j] = mask[j] && (KW_TEXT[j][b +: 8] == c);
      end
    end
    return nm;
  endfunction

  // Keyword whose full text was matched
  function automatic code_match_t kw_code(logic [NKW-1:0] mask, logic [3:0] cnt);
    code_match_t m;
    m = '0;
    for (int j = 0; j < NKW; j++) begin
      if (mask[j] && (KW_SIZE[j] == cnt)) begin
        m.hit  = 1'b1;
        m.code = m.code | 5'(j);
      end
    end
    return m;
  endfunction

endpackage

// File: sv/stt_scan.sv
// Tokenizer scan state and the per-item token logic.
`timescale 1ns / 1ps

module stt_scan #(
  parameter int MAX_LINE = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  stt_pkg::char_t     item,
  output stt_pkg::step_out_t res
);

  localparam int                      CAP    = (MAX_LINE < 4096) ? MAX_LINE : 4096;
  localparam logic [stt_pkg::POS_W-1:0] CAP_V  = stt_pkg::POS_W'(CAP);
  localparam logic [stt_pkg::POS_W-1:0] CAP_M1 = stt_pkg::POS_W'(CAP - 1);

  typedef enum logic [2:0] {
    M_IDLE, M_STRING, M_INT, M_FRAC, M_IDENT, M_OPER
  } mode_t;

  mode_t                       mode, mode_next;
  logic [stt_pkg::POS_W-1:0]   pos, pos_next;
  logic [stt_pkg::POS_W-1:0]   start, start_next;
  logic                        ovf, ovf_next;
  logic [stt_pkg::NKW-1:0]     kmask, kmask_next;
  logic [3:0]                  kcnt, kcnt_next;
  logic [7:0]                  pend, pend_next;

  logic [7:0]            c;
  logic                  at_cap, touched, do_ff;
  logic                  fin_valid;
  stt_pkg::token_t       fin, fr_res;
  mode_t                 fr_mode;
  logic                  fr_begin, fr_ident, fr_oper, fr_emit;
  stt_pkg::code_match_t  kw_m, op_m, pair_m;

  // Build one token from its span; end and start are clipped at the line limit
  function automatic stt_pkg::token_t emit(logic [2:0] kind, logic [4:0] code,
                                           logic [stt_pkg::POS_W-1:0] st, logic o,
                                           logic [stt_pkg::POS_W-1:0] p, logic plus);
    logic [stt_pkg::POS_W:0]   e;
    logic [stt_pkg::POS_W-1:0] ec, ln, sc;
    stt_pkg::token_t           r;
    e  = {1'b0, p} + {{stt_pkg::POS_W{1'b0}}, plus};
    ec = (e > {1'b0, CAP_V}) ? CAP_V : e[stt_pkg::POS_W-1:0];
    ln = (ec > st) ? ec - st : stt_pkg::POS_W'(1);
    sc = (st > CAP_M1) ? CAP_M1 : st;
    r.token_kind   = kind;
    r.table_code   = code;
    r.token_start  = sc[11:0];
    r.token_length = ln;
    r.clipped      = o;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  assign c       = item.byte_value;
  assign at_cap  = (pos >= CAP_V);
  assign touched = ovf | at_cap;
  assign kw_m    = stt_pkg::kw_code(kmask, kcnt);
  assign op_m    = stt_pkg::single_code(pend);
  assign pair_m  = stt_pkg::pair_code(pend, c);

  // Token that closes before the current character
  always_comb begin
    fin_valid = (mode != M_IDLE);
    unique case (mode)
      M_STRING, M_INT, M_FRAC: fin = emit(stt_pkg::KIND_LITERAL, 5'd0, start, ovf, pos, 1'b0);
      M_IDENT: fin = kw_m.hit ?
                     emit(stt_pkg::KIND_KEYWORD, kw_m.code, start, ovf, pos, 1'b0) :
                     emit(stt_pkg::KIND_IDENTIFIER, 5'd0, start, ovf, pos, 1'b0);
      M_OPER:  fin = op_m.hit ?
                     emit(stt_pkg::KIND_OPERATOR, op_m.code, start, ovf, pos, 1'b0) :
                     emit(stt_pkg::KIND_OTHER, 5'd0, start, ovf, pos, 1'b0);
      default: fin = '0;
    endcase
  end

  // Classify a character that opens a new token
  always_comb begin
    fr_ident = 1'b0;
    fr_oper  = 1'b0;
    fr_emit  = 1'b0;
    fr_begin = 1'b1;
    if (stt_pkg::is_space(c)) begin
      fr_mode  = M_IDLE;
      fr_begin = 1'b0;
    end else if (c == "\"") begin
      fr_mode = M_STRING;
    end else if (stt_pkg::is_digit(c)) begin
      fr_mode = M_INT;
    end else if (stt_pkg::is_ident_start(c)) begin
      fr_mode  = M_IDENT;
      fr_ident = 1'b1;
    end else if (stt_pkg::is_op_char(c)) begin
      fr_mode = M_OPER;
      fr_oper = 1'b1;
    end else begin
      fr_mode = M_IDLE;
      fr_emit = 1'b1;
    end
    fr_res = emit(stt_pkg::KIND_OTHER, 5'd0, pos, at_cap, pos, 1'b1);
  end

  // Next state and the tokens of this item
  always_comb begin
    mode_next  = mode;
    pos_next   = pos;
    start_next = start;
    ovf_next   = ovf;
    kmask_next = kmask;
    kcnt_next  = kcnt;
    pend_next  = pend;
    do_ff      = 1'b0;
    res        = '0;
    if (item.command == stt_pkg::CMD_EOL) begin
      if (fin_valid) begin
        res.count = 2'd1;
        res.first = fin;
      end
      mode_next  = M_IDLE;
      pos_next   = '0;
      start_next = '0;
      ovf_next   = 1'b0;
      kmask_next = '1;
      kcnt_next  = '0;
      pend_next  = '0;
    end else begin
      unique case (mode)
        M_STRING: begin
          ovf_next = touched;
          if (c == "\"") begin
            res.count = 2'd1;
            res.first = emit(stt_pkg::KIND_LITERAL, 5'd0, start, touched, pos, 1'b1);
            mode_next = M_IDLE;
          end
        end
        M_INT: begin
          if (stt_pkg::is_digit(c)) begin
            ovf_next = touched;
          end else if (c == ".") begin
            ovf_next  = touched;
            mode_next = M_FRAC;
          end else begin
            do_ff = 1'b1;
          end
        end
        M_FRAC: begin
          if (stt_pkg::is_digit(c)) ovf_next = touched;
          else do_ff = 1'b1;
        end
        M_IDENT: begin
          if (stt_pkg::is_ident_start(c) || stt_pkg::is_digit(c)) begin
            ovf_next   = touched;
            kmask_next = stt_pkg::kw_step(kmask, kcnt, c);
            kcnt_next  = (kcnt == 4'hF) ? kcnt : kcnt + 4'd1;
          end else begin
            do_ff = 1'b1;
          end
        end
        M_OPER: begin
          if ((pend == ".") && stt_pkg::is_digit(c)) begin
            ovf_next  = touched;
            mode_next = M_FRAC;
          end else if (pair_m.hit) begin
            ovf_next  = touched;
            res.count = 2'd1;
            res.first = emit(stt_pkg::KIND_OPERATOR, pair_m.code, start, touched, pos, 1'b1);
            mode_next = M_IDLE;
          end else begin
            do_ff = 1'b1;
          end
        end
        default: do_ff = 1'b1;
      endcase

      // Close the pending token, then start from this character
      if (do_ff) begin
        mode_next = fr_mode;
        if (fr_begin) begin
          start_next = pos;
          ovf_next   = at_cap;
          kmask_next = fr_ident ? stt_pkg::kw_step('1, 4'd0, c) : '1;
          kcnt_next  = fr_ident ? 4'd1 : 4'd0;
        end
        if (fr_oper) pend_next = c;
        if (fin_valid && fr_emit) begin
          res.count  = 2'd2;
          res.first  = fin;
          res.second = fr_res;
        end else if (fin_valid) begin
          res.count = 2'd1;
          res.first = fin;
        end else if (fr_emit) begin
          res.count = 2'd1;
          res.first = fr_res;
        end
      end

      if (!at_cap) pos_next = pos + stt_pkg::POS_W'(1);
    end

    // Mark the last token of the item
    if (res.count == 2'd1) res.first.last_of_run = 1'b1;
    if (res.count == 2'd2) res.second.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      pos   <= '0;
      start <= '0;
      ovf   <= 1'b0;
      kmask <= '1;
      kcnt  <= '0;
      pend  <= '0;
    end else if (step) begin
      mode  <= mode_next;
      pos   <= pos_next;
      start <= start_next;
      ovf   <= ovf_next;
      kmask <= kmask_next;
      kcnt  <= kcnt_next;
      pend  <= pend_next;
    end
  end

endmodule

// File: sv/source_text_tokenizer.sv
// Streaming source text tokenizer: input stage, scanner and token output register.
//
// The char channel (char_valid, char_stall, char_item) takes one byte or an
// end-of-line command per item; the token channel (token_valid, token_stall,
// token_item) gives one token per item, last_of_run marking the final token
// that an input item caused. An item moves at a clock edge where valid is high
// and stall is low.
// An accepted item waits in the input stage; its tokens are registered in the
// output register and leave from there.
// Throughput: one item per cycle while token_stall is low and each item yields
// at most one token. The output register hands over one token per cycle, so
// after a two-token item the next item waits until the second token leaves.
// The input stage is only held while the output register is busy: char_stall is
// high when the input stage holds an item and the output register holds two
// tokens, or one token while token_stall is high.
// Reset (rst, synchronous) empties both stages and sets the scanner to the
// start of a line. Lengths saturate at min(MAX_LINE, 4096), offsets at one less.
`timescale 1ns / 1ps
`include "source_text_tokenizer_defines.svh"

module source_text_tokenizer #(
  parameter int MAX_LINE = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            char_valid,
  output logic            char_stall,
  input  stt_pkg::char_t  char_item,
  output logic            token_valid,
  input  logic            token_stall,
  output stt_pkg::token_t token_item
);

  logic               s_valid;
  stt_pkg::char_t     s_item;
  logic [1:0]         res_cnt;
  stt_pkg::token_t    r0, r1;
  stt_pkg::step_out_t sr;
  logic               tok_acc, adv, step;

  assign tok_acc    = token_valid && !token_stall;
  // Output register frees up this cycle
  assign adv        = (res_cnt == 2'd0) || ((res_cnt == 2'd1) && tok_acc);
  assign char_stall = s_valid && !adv;
  assign step       = s_valid && adv;

  stt_scan #(
    .MAX_LINE(MAX_LINE)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (s_item),
    .res  (sr)
  );

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!char_stall) begin
      s_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) s_item <= char_item;
  end

  // Token output register, second token shifts forward after the first leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 2'd0;
    end else if (adv) begin
      res_cnt <= step ? sr.count : 2'd0;
    end else if (tok_acc) begin
      res_cnt <= 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r0 <= sr.first;
      r1 <= sr.second;
    end else if (tok_acc) begin
      r0 <= r1;
    end
  end

  assign token_valid = (res_cnt != 2'd0);
  assign token_item  = r0;

  // Checks
  `STT_ASSERT_NEXT(a_stage_drains, s_valid && (res_cnt == 2'd0) && !char_valid, !s_valid, "input stage not consumed with empty output register")
  `STT_ASSERT_NEXT(a_second_follows, tok_acc && (res_cnt == 2'd2), token_valid && (res_cnt == 2'd1), "second token of an item lost")
  `STT_ASSERT_NOW(a_last_mark, token_valid && !token_item.last_of_run, res_cnt == 2'd2, "token without last mark has no follower")

endmodule
